@@ design/caf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Complementary attitude filter package
// Shared constants, sequencer types and the arctangent table of the
// vectoring rotation unit.
// ----------------------------------------------------------------------------
package caf_pkg;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 21;

   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_STEP_GAIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUPLING_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_WEIGHT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_OFFSET   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROLL_OFFSET    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADJUST_GAIN    = 3'd5;

   // Register reset values.
   localparam logic [20:0]        GYRO_GAIN_RESET     = 21'd262423;
   localparam logic [15:0]        COUPLING_GAIN_RESET = 16'd4578;
   localparam logic [16:0]        BLEND_WEIGHT_RESET  = 17'd65503;
   localparam logic signed [12:0] PITCH_OFFSET_RESET  = -13'sd256;
   localparam logic signed [12:0] ROLL_OFFSET_RESET   = 13'sd256;
   localparam logic [7:0]         ADJUST_GAIN_RESET   = 8'd15;

   // Shift-add multiplier: 64-bit multiplicand, 26-bit two's complement multiplier.
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 26;

   // Square root and rotation unit widths.
   localparam int SQ_W       = 42;
   localparam int CORDIC_W   = 32;
   localparam int CORDIC_Z_W = 25;

   // Unity blend weight in Q1.16 and the reciprocal used to divide by six.
   localparam logic [16:0] WEIGHT_ONE  = 17'd65536;
   localparam logic [13:0] DIV6_RECIP  = 14'd10923;

   // Sequencer states.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_ISSUE  = 7'b0000010,
      ST_MUL    = 7'b0000100,
      ST_SQRT   = 7'b0001000,
      ST_CORDIC = 7'b0010000,
      ST_RETIRE = 7'b0100000,
      ST_OUTPUT = 7'b1000000
   } state_type;

   // Program steps of one item, in execution order.
   typedef enum logic [4:0] {
      STEP_INC_ROLL     = 5'd0,
      STEP_INC_PITCH    = 5'd1,
      STEP_SIN_ARG      = 5'd2,
      STEP_SIN_SQ       = 5'd3,
      STEP_SIN_CUBE     = 5'd4,
      STEP_SIN_FIN      = 5'd5,
      STEP_CROSS_PITCH  = 5'd6,
      STEP_CROSS_ROLL   = 5'd7,
      STEP_SQ_X         = 5'd8,
      STEP_SQ_Y         = 5'd9,
      STEP_SQ_Z         = 5'd10,
      STEP_PITCH_SQRT   = 5'd11,
      STEP_PITCH_CORDIC = 5'd12,
      STEP_ROLL_SQRT    = 5'd13,
      STEP_ROLL_CORDIC  = 5'd14,
      STEP_BLEND_PA     = 5'd15,
      STEP_BLEND_PR     = 5'd16,
      STEP_BLEND_RA     = 5'd17,
      STEP_BLEND_RR     = 5'd18,
      STEP_OUT          = 5'd19
   } step_type;

   // Arctangent of 2^-i in degrees * 2^16.
   function automatic logic signed [CORDIC_Z_W-1:0] cordic_atan(input logic [3:0] idx);
      case (idx)
         4'd0:    return 25'sd2949120;
         4'd1:    return 25'sd1740967;
         4'd2:    return 25'sd919879;
         4'd3:    return 25'sd466945;
         4'd4:    return 25'sd234379;
         4'd5:    return 25'sd117304;
         4'd6:    return 25'sd58666;
         4'd7:    return 25'sd29335;
         4'd8:    return 25'sd14668;
         4'd9:    return 25'sd7334;
         4'd10:   return 25'sd3667;
         4'd11:   return 25'sd1833;
         4'd12:   return 25'sd917;
         4'd13:   return 25'sd458;
         4'd14:   return 25'sd229;
         4'd15:   return 25'sd115;
         default: return 25'sd0;
      endcase
   endfunction

   // Round half up, then arithmetic shift right.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned sh);
      logic signed [63:0] half;
      half = (64'sd1 <<< sh) >>> 1;
      return (v + half) >>> sh;
   endfunction

endpackage
`default_nettype wire

@@ design/complementary_attitude_filter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One item in flight: a new item is accepted only once the previous result has
// been handed to the output register. Each item takes fourteen passes of the
// shared shift-add multiplier, up to two 21-step square roots and up to two
// 16-step rotations.
// Synchronous active-high reset restores register defaults and zeroes angles.
// ----------------------------------------------------------------------------
// Complementary attitude filter core
// Integrates gyro rates into roll and pitch, applies yaw cross-coupling,
// derives accelerometer reference angles and blends them into the angles.
// ----------------------------------------------------------------------------
module complementary_attitude_filter_core #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Configuration port
   input  wire logic                            csr_write,
   input  wire logic [caf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [caf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Input items
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [17:0]              req_roll_rate,
   input  wire logic signed [17:0]              req_pitch_rate,
   input  wire logic signed [17:0]              req_yaw_rate,
   input  wire logic signed [15:0]              req_accel_x,
   input  wire logic signed [15:0]              req_accel_y,
   input  wire logic signed [15:0]              req_accel_z,
   // Result items
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [17:0]                   rsp_pitch_out,
   output logic signed [17:0]                   rsp_roll_out,
   output logic signed [25:0]                   rsp_pitch_adjust_out,
   output logic signed [25:0]                   rsp_roll_adjust_out,
   output logic signed [15:0]                   rsp_pitch_ref_out,
   output logic signed [15:0]                   rsp_roll_ref_out
);
   import caf_pkg::*;

   localparam int ANGLE_W     = ANGLE_FRAC_BITS + 11;
   localparam int GYRO_SHIFT  = 40 - ANGLE_FRAC_BITS;
   localparam int OUT_SHIFT   = ANGLE_FRAC_BITS - 8;
   localparam int REF_DN      = (ANGLE_FRAC_BITS >= 16) ? 0 : 16 - ANGLE_FRAC_BITS;
   localparam int REF_UP      = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;
   localparam logic signed [63:0] REF_HALF  = (64'sd1 <<< REF_DN) >>> 1;
   localparam logic signed [63:0] ANGLE_LIM = 64'sd360 <<< ANGLE_FRAC_BITS;
   localparam logic [4:0]         MUL_LAST  = 5'(MUL_B_W - 1);
   localparam logic [SQ_W-1:0]    SQ_START  = SQ_W'(1) << (SQ_W - 2);

   // Control state
   state_type state_ff, state_in;
   step_type  pc_ff, pc_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Configuration registers
   logic [20:0]        gyro_gain_ff, gyro_gain_in;
   logic [15:0]        coupling_gain_ff, coupling_gain_in;
   logic [16:0]        blend_weight_ff, blend_weight_in;
   logic signed [12:0] pitch_off_ff, pitch_off_in;
   logic signed [12:0] roll_off_ff, roll_off_in;
   logic [7:0]         adjust_gain_ff, adjust_gain_in;

   // Filter state
   logic signed [ANGLE_W-1:0] roll_ff, roll_in;
   logic signed [ANGLE_W-1:0] pitch_ff, pitch_in;
   logic signed [23:0]        pitch_ref_ff, pitch_ref_in;
   logic signed [23:0]        roll_ref_ff, roll_ref_in;

   // Latched item
   logic signed [17:0] rr_ff, rr_in, pr_ff, pr_in, yr_ff, yr_in;
   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;

   // Working registers
   logic signed [23:0] s_ff, s_in, aux_ff, aux_in, sn_ff, sn_in;
   logic [31:0]        sum_ff, sum_in, sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic               ok_ff, ok_in;
   logic signed [63:0] bacc_ff, bacc_in;

   // Shift-add multiplier
   logic signed [MUL_A_W-1:0] mcand_ff, mcand_in, prod_ff, prod_in;
   logic [MUL_B_W-1:0]        mplier_ff, mplier_in;
   logic [4:0]                mcount_ff, mcount_in;

   // Square root unit
   logic [SQ_W-1:0] rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic [SQ_W-1:0] sq_trial;

   // Rotation unit
   logic signed [CORDIC_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CORDIC_Z_W-1:0] cz_ff, cz_in;
   logic [3:0]                   citer_ff, citer_in;
   logic signed [CORDIC_W-1:0]   cx_shift, cy_shift;

   // Result registers
   logic signed [17:0] pitch_out_ff, pitch_out_in, roll_out_ff, roll_out_in;
   logic signed [25:0] pitch_adj_ff, pitch_adj_in, roll_adj_ff, roll_adj_in;
   logic signed [15:0] pitch_rout_ff, pitch_rout_in, roll_rout_ff, roll_rout_in;

   // Helper values
   logic                      mul_load;
   logic signed [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic [16:0]               w_eff, w_comp;
   logic signed [63:0]        pref_ang, rref_ang;
   logic signed [63:0]        blend_v, blend_sat;
   logic [23:0]               d6_abs;
   logic [29:0]               d6_prod;
   logic signed [23:0]        d6_quot;
   logic signed [17:0]        po, ro;
   logic signed [26:0]        pitch_adj_full, roll_adj_full;

   // Combinational helpers shared by several steps.
   always_comb begin
      w_eff    = (blend_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_ff;
      w_comp   = WEIGHT_ONE - w_eff;
      pref_ang = ((64'(pitch_ref_ff) + REF_HALF) >>> REF_DN) <<< REF_UP;
      rref_ang = ((64'(roll_ref_ff) + REF_HALF) >>> REF_DN) <<< REF_UP;
      blend_v  = round_shift(bacc_ff + prod_ff, 16);
      if (blend_v > ANGLE_LIM) begin
         blend_sat = ANGLE_LIM;
      end else if (blend_v < -ANGLE_LIM) begin
         blend_sat = -ANGLE_LIM;
      end else begin
         blend_sat = blend_v;
      end
      // Division of the cubic term by six, truncating toward zero.
      d6_abs  = aux_ff[23] ? 24'(-aux_ff) : 24'(aux_ff);
      d6_prod = 30'(d6_abs[15:0]) * 30'(DIV6_RECIP);
      d6_quot = aux_ff[23] ? -24'(d6_prod[29:16]) : 24'(d6_prod[29:16]);
      sq_trial = root_ff + bit_ff;
      cx_shift = cx_ff >>> citer_ff;
      cy_shift = cy_ff >>> citer_ff;
      po = 18'(round_shift(64'(pitch_ff), OUT_SHIFT));
      ro = 18'(round_shift(64'(roll_ff), OUT_SHIFT));
      pitch_adj_full = po * $signed({1'b0, adjust_gain_ff});
      roll_adj_full  = ro * $signed({1'b0, adjust_gain_ff});
   end

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in         = state_ff;
      pc_in            = pc_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      gyro_gain_in     = gyro_gain_ff;
      coupling_gain_in = coupling_gain_ff;
      blend_weight_in  = blend_weight_ff;
      pitch_off_in     = pitch_off_ff;
      roll_off_in      = roll_off_ff;
      adjust_gain_in   = adjust_gain_ff;
      roll_in          = roll_ff;
      pitch_in         = pitch_ff;
      pitch_ref_in     = pitch_ref_ff;
      roll_ref_in      = roll_ref_ff;
      rr_in            = rr_ff;
      pr_in            = pr_ff;
      yr_in            = yr_ff;
      ax_in            = ax_ff;
      ay_in            = ay_ff;
      az_in            = az_ff;
      s_in             = s_ff;
      aux_in           = aux_ff;
      sn_in            = sn_ff;
      sum_in           = sum_ff;
      sqx_in           = sqx_ff;
      sqy_in           = sqy_ff;
      ok_in            = ok_ff;
      bacc_in          = bacc_ff;
      mcand_in         = mcand_ff;
      prod_in          = prod_ff;
      mplier_in        = mplier_ff;
      mcount_in        = mcount_ff;
      rem_in           = rem_ff;
      root_in          = root_ff;
      bit_in           = bit_ff;
      cx_in            = cx_ff;
      cy_in            = cy_ff;
      cz_in            = cz_ff;
      citer_in         = citer_ff;
      pitch_out_in     = pitch_out_ff;
      roll_out_in      = roll_out_ff;
      pitch_adj_in     = pitch_adj_ff;
      roll_adj_in      = roll_adj_ff;
      pitch_rout_in    = pitch_rout_ff;
      roll_rout_in     = roll_rout_ff;
      mul_load         = 1'b0;
      mul_a            = '0;
      mul_b            = '0;

      // Configuration writes; unknown indexes are ignored.
      if (csr_write) begin
         case (csr_index)
            CSR_GYRO_STEP_GAIN: gyro_gain_in     = csr_wdata[20:0];
            CSR_COUPLING_GAIN:  coupling_gain_in = csr_wdata[15:0];
            CSR_BLEND_WEIGHT:   blend_weight_in  = csr_wdata[16:0];
            CSR_PITCH_OFFSET:   pitch_off_in     = csr_wdata[12:0];
            CSR_ROLL_OFFSET:    roll_off_in      = csr_wdata[12:0];
            CSR_ADJUST_GAIN:    adjust_gain_in   = csr_wdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         // Wait for an item and latch it.
         ST_IDLE: begin
            if (req_valid) begin
               rr_in    = req_roll_rate;
               pr_in    = req_pitch_rate;
               yr_in    = req_yaw_rate;
               ax_in    = req_accel_x;
               ay_in    = req_accel_y;
               az_in    = req_accel_z;
               pc_in    = STEP_INC_ROLL;
               state_in = ST_ISSUE;
            end
         end

         // Load the unit that the current step needs.
         ST_ISSUE: begin
            state_in = ST_RETIRE;
            case (pc_ff)
               STEP_INC_ROLL: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(gyro_gain_ff);
                  mul_b    = 26'(rr_ff);
               end
               STEP_INC_PITCH: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(gyro_gain_ff);
                  mul_b    = 26'(pr_ff);
               end
               STEP_SIN_ARG: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(coupling_gain_ff);
                  mul_b    = 26'(yr_ff);
               end
               STEP_SIN_SQ: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(s_ff);
                  mul_b    = 26'(s_ff);
               end
               STEP_SIN_CUBE: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(aux_ff);
                  mul_b    = 26'(s_ff);
               end
               STEP_CROSS_PITCH: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(roll_ff);
                  mul_b    = 26'(sn_ff);
               end
               STEP_CROSS_ROLL: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(pitch_ff);
                  mul_b    = 26'(sn_ff);
               end
               STEP_SQ_X: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(ax_ff);
                  mul_b    = 26'(ax_ff);
               end
               STEP_SQ_Y: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(ay_ff);
                  mul_b    = 26'(ay_ff);
               end
               STEP_SQ_Z: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(az_ff);
                  mul_b    = 26'(az_ff);
               end
               STEP_PITCH_SQRT: begin
                  ok_in = (sqy_ff < sum_ff);
                  if (sqy_ff < sum_ff) begin
                     rem_in   = {2'b00, sum_ff - sqy_ff, 8'h00};
                     root_in  = '0;
                     bit_in   = SQ_START;
                     state_in = ST_SQRT;
                  end
               end
               STEP_ROLL_SQRT: begin
                  ok_in = (sqx_ff < sum_ff);
                  if (sqx_ff < sum_ff) begin
                     rem_in   = {2'b00, sum_ff - sqx_ff, 8'h00};
                     root_in  = '0;
                     bit_in   = SQ_START;
                     state_in = ST_SQRT;
                  end
               end
               STEP_PITCH_CORDIC: begin
                  if (ok_ff) begin
                     cx_in    = $signed(32'(root_ff[21:0]) << 8);
                     cy_in    = 32'(ay_ff) <<< 12;
                     cz_in    = '0;
                     citer_in = '0;
                     state_in = ST_CORDIC;
                  end
               end
               STEP_ROLL_CORDIC: begin
                  if (ok_ff) begin
                     cx_in    = $signed(32'(root_ff[21:0]) << 8);
                     cy_in    = 32'(ax_ff) <<< 12;
                     cz_in    = '0;
                     citer_in = '0;
                     state_in = ST_CORDIC;
                  end
               end
               STEP_BLEND_PA: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(pitch_ff);
                  mul_b    = {9'b0, w_eff};
               end
               STEP_BLEND_PR: begin
                  mul_load = 1'b1;
                  mul_a    = pref_ang;
                  mul_b    = {9'b0, w_comp};
               end
               STEP_BLEND_RA: begin
                  mul_load = 1'b1;
                  mul_a    = 64'(roll_ff);
                  mul_b    = {9'b0, w_eff};
               end
               STEP_BLEND_RR: begin
                  mul_load = 1'b1;
                  mul_a    = rref_ang;
                  mul_b    = {9'b0, w_comp};
               end
               STEP_OUT: begin
                  state_in = ST_OUTPUT;
               end
               default: ;
            endcase
            if (mul_load) begin
               mcand_in  = mul_a;
               mplier_in = mul_b;
               prod_in   = '0;
               mcount_in = '0;
               state_in  = ST_MUL;
            end
         end

         // One multiplier bit per cycle; the top bit carries negative weight.
         ST_MUL: begin
            if (mplier_ff[0]) begin
               if (mcount_ff == MUL_LAST) begin
                  prod_in = prod_ff - mcand_ff;
               end else begin
                  prod_in = prod_ff + mcand_ff;
               end
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            mcount_in = mcount_ff + 5'd1;
            if (mcount_ff == MUL_LAST) begin
               state_in = ST_RETIRE;
            end
         end

         // One result bit of the square root per cycle.
         ST_SQRT: begin
            if (rem_ff >= sq_trial) begin
               rem_in  = rem_ff - sq_trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_RETIRE;
            end
         end

         // One vectoring rotation per cycle drives y toward zero.
         ST_CORDIC: begin
            if (cy_ff > 32'sd0) begin
               cx_in = cx_ff + cy_shift;
               cy_in = cy_ff - cx_shift;
               cz_in = cz_ff + cordic_atan(citer_ff);
            end else begin
               cx_in = cx_ff - cy_shift;
               cy_in = cy_ff + cx_shift;
               cz_in = cz_ff - cordic_atan(citer_ff);
            end
            citer_in = citer_ff + 4'd1;
            if (citer_ff == 4'd15) begin
               state_in = ST_RETIRE;
            end
         end

         // Write the step's result to its destination and advance.
         ST_RETIRE: begin
            case (pc_ff)
               STEP_INC_ROLL:
                  roll_in = ANGLE_W'(64'(roll_ff) + round_shift(prod_ff, GYRO_SHIFT));
               STEP_INC_PITCH:
                  pitch_in = ANGLE_W'(64'(pitch_ff) + round_shift(prod_ff, GYRO_SHIFT));
               STEP_SIN_ARG:     s_in   = 24'(round_shift(prod_ff, 10));
               STEP_SIN_SQ:      aux_in = 24'(round_shift(prod_ff, 30));
               STEP_SIN_CUBE:    aux_in = 24'(round_shift(prod_ff, 30));
               STEP_SIN_FIN:     sn_in  = s_ff - d6_quot;
               STEP_CROSS_PITCH:
                  pitch_in = ANGLE_W'(64'(pitch_ff) - round_shift(prod_ff, 30));
               STEP_CROSS_ROLL:
                  roll_in = ANGLE_W'(64'(roll_ff) + round_shift(prod_ff, 30));
               STEP_SQ_X: begin
                  sqx_in = prod_ff[31:0];
                  sum_in = prod_ff[31:0];
               end
               STEP_SQ_Y: begin
                  sqy_in = prod_ff[31:0];
                  sum_in = sum_ff + prod_ff[31:0];
               end
               STEP_SQ_Z:        sum_in = sum_ff + prod_ff[31:0];
               STEP_PITCH_CORDIC: begin
                  if (ok_ff) begin
                     pitch_ref_in = 24'(32'(cz_ff) + (32'(pitch_off_ff) <<< 8));
                  end
               end
               STEP_ROLL_CORDIC: begin
                  if (ok_ff) begin
                     roll_ref_in = 24'((32'(roll_off_ff) <<< 8) - 32'(cz_ff));
                  end
               end
               STEP_BLEND_PA:    bacc_in  = prod_ff;
               STEP_BLEND_PR:    pitch_in = ANGLE_W'(blend_sat);
               STEP_BLEND_RA:    bacc_in  = prod_ff;
               STEP_BLEND_RR:    roll_in  = ANGLE_W'(blend_sat);
               default: ;
            endcase
            pc_in    = step_type'(pc_ff + 5'd1);
            state_in = ST_ISSUE;
         end

         // Hand the result item to the output register once it is free.
         ST_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               pitch_out_in  = po;
               roll_out_in   = ro;
               pitch_adj_in  = 26'(pitch_adj_full);
               roll_adj_in   = 26'(roll_adj_full);
               pitch_rout_in = 16'(round_shift(64'(pitch_ref_ff), 8));
               roll_rout_in  = 16'(round_shift(64'(roll_ref_ff), 8));
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control and filter state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         pc_ff            <= STEP_INC_ROLL;
         rsp_valid_ff     <= 1'b0;
         gyro_gain_ff     <= GYRO_GAIN_RESET;
         coupling_gain_ff <= COUPLING_GAIN_RESET;
         blend_weight_ff  <= BLEND_WEIGHT_RESET;
         pitch_off_ff     <= PITCH_OFFSET_RESET;
         roll_off_ff      <= ROLL_OFFSET_RESET;
         adjust_gain_ff   <= ADJUST_GAIN_RESET;
         roll_ff          <= '0;
         pitch_ff         <= '0;
         pitch_ref_ff     <= '0;
         roll_ref_ff      <= '0;
      end else begin
         state_ff         <= state_in;
         pc_ff            <= pc_in;
         rsp_valid_ff     <= rsp_valid_in;
         gyro_gain_ff     <= gyro_gain_in;
         coupling_gain_ff <= coupling_gain_in;
         blend_weight_ff  <= blend_weight_in;
         pitch_off_ff     <= pitch_off_in;
         roll_off_ff      <= roll_off_in;
         adjust_gain_ff   <= adjust_gain_in;
         roll_ff          <= roll_in;
         pitch_ff         <= pitch_in;
         pitch_ref_ff     <= pitch_ref_in;
         roll_ref_ff      <= roll_ref_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      rr_ff         <= rr_in;
      pr_ff         <= pr_in;
      yr_ff         <= yr_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      az_ff         <= az_in;
      s_ff          <= s_in;
      aux_ff        <= aux_in;
      sn_ff         <= sn_in;
      sum_ff        <= sum_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      ok_ff         <= ok_in;
      bacc_ff       <= bacc_in;
      mcand_ff      <= mcand_in;
      prod_ff       <= prod_in;
      mplier_ff     <= mplier_in;
      mcount_ff     <= mcount_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      cz_ff         <= cz_in;
      citer_ff      <= citer_in;
      pitch_out_ff  <= pitch_out_in;
      roll_out_ff   <= roll_out_in;
      pitch_adj_ff  <= pitch_adj_in;
      roll_adj_ff   <= roll_adj_in;
      pitch_rout_ff <= pitch_rout_in;
      roll_rout_ff  <= roll_rout_in;
   end

   // Ports.
   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pitch_out        = pitch_out_ff;
   assign rsp_roll_out         = roll_out_ff;
   assign rsp_pitch_adjust_out = pitch_adj_ff;
   assign rsp_roll_adjust_out  = roll_adj_ff;
   assign rsp_pitch_ref_out    = pitch_rout_ff;
   assign rsp_roll_ref_out     = roll_rout_ff;

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complementary attitude filter core testbench
// Drives IMU sample items through a bursty sender, stalls results on a random
// pattern, and compares every result with an in-bench attitude predictor that
// tracks the register settings across several configuration phases.
// ----------------------------------------------------------------------------
module tb;
   import caf_pkg::*;

   localparam int QUIET_LIMIT = 6000;
   localparam int SETTLE_CYCLES = 600;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic signed [17:0] roll_rate;
      logic signed [17:0] pitch_rate;
      logic signed [17:0] yaw_rate;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } imu_sample_type;

   typedef struct {
      logic signed [17:0] pitch_out;
      logic signed [17:0] roll_out;
      logic signed [25:0] pitch_adjust_out;
      logic signed [25:0] roll_adjust_out;
      logic signed [15:0] pitch_ref_out;
      logic signed [15:0] roll_ref_out;
   } attitude_type;

   // Arctangent of 2^-i in degrees * 2^16.
   localparam longint ATAN_DEG[16] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [17:0] req_roll_rate = '0, req_pitch_rate = '0, req_yaw_rate = '0;
   logic signed [15:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [17:0] rsp_pitch_out, rsp_roll_out;
   logic signed [25:0] rsp_pitch_adjust_out, rsp_roll_adjust_out;
   logic signed [15:0] rsp_pitch_ref_out, rsp_roll_ref_out;

   complementary_attitude_filter_core i_dut (.*);

   always #5 clock = ~clock;

   // Predictor copy of the registers and the filter state.
   logic [20:0]        gyro_gain = GYRO_GAIN_RESET;
   logic [15:0]        coupling_gain = COUPLING_GAIN_RESET;
   logic [16:0]        blend_weight = BLEND_WEIGHT_RESET;
   logic signed [12:0] pitch_offset = PITCH_OFFSET_RESET;
   logic signed [12:0] roll_offset = ROLL_OFFSET_RESET;
   logic [7:0]         adjust_gain = ADJUST_GAIN_RESET;
   longint roll_est = 0, pitch_est = 0, pitch_ref = 0, roll_ref = 0;

   imu_sample_type sample_q[$];
   attitude_type   attitude_q[$];
   imu_sample_type sample_on_bus;
   int error_count = 0;
   bit req_taken = 1'b0;

   function automatic longint round_up(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned a);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > a) b >>= 2;
      while (b != 0) begin
         if (a >= res + b) begin
            a -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Arcsine of t / sqrt(sum) in degrees * 2^16, by vectoring rotation.
   function automatic longint arcsine_deg(longint t, longint unsigned sum);
      longint xv, yv, z, xs, ys;
      xv = longint'(int_sqrt((sum - longint'(t * t)) << 8)) * 256;
      yv = t * 4096;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         xs = xv >>> i;
         ys = yv >>> i;
         if (yv > 0) begin
            xv = xv + ys;
            yv = yv - xs;
            z += ATAN_DEG[i];
         end else begin
            xv = xv - ys;
            yv = yv + xs;
            z -= ATAN_DEG[i];
         end
      end
      return z;
   endfunction

   function automatic longint blend_clamp(longint a, longint r, longint w);
      longint v;
      v = round_up(a * w + r * (65536 - w), 16);
      if (v > 360 * 65536) v = 360 * 65536;
      if (v < -360 * 65536) v = -360 * 65536;
      return v;
   endfunction

   // Advances the predicted filter state by one item and returns its result.
   function automatic attitude_type predict_attitude(imu_sample_type s);
      attitude_type r;
      longint ax, ay, az, sa, sa2, sa3, sn, w, po, ro, pa, ra;
      longint unsigned sum;
      ax = s.accel_x;
      ay = s.accel_y;
      az = s.accel_z;
      roll_est += round_up(longint'(s.roll_rate) * longint'(gyro_gain), 24);
      pitch_est += round_up(longint'(s.pitch_rate) * longint'(gyro_gain), 24);
      sa = round_up(longint'(s.yaw_rate) * longint'(coupling_gain), 10);
      sa2 = round_up(sa * sa, 30);
      sa3 = round_up(sa2 * sa, 30);
      sn = sa - sa3 / 6;
      pitch_est -= round_up(roll_est * sn, 30);
      roll_est += round_up(pitch_est * sn, 30);
      sum = ax * ax + ay * ay + az * az;
      // A fresh reference only when the axis lies strictly below the magnitude.
      if (longint'(ay * ay) < sum)
         pitch_ref = arcsine_deg(ay, sum) + longint'(pitch_offset) * 256;
      if (longint'(ax * ax) < sum)
         roll_ref = -arcsine_deg(ax, sum) + longint'(roll_offset) * 256;
      w = (blend_weight > WEIGHT_ONE) ? 65536 : longint'(blend_weight);
      pitch_est = blend_clamp(pitch_est, pitch_ref, w);
      roll_est = blend_clamp(roll_est, roll_ref, w);
      po = round_up(pitch_est, 8);
      ro = round_up(roll_est, 8);
      pa = po * longint'(adjust_gain);
      ra = ro * longint'(adjust_gain);
      r.pitch_out = po[17:0];
      r.roll_out = ro[17:0];
      r.pitch_adjust_out = pa[25:0];
      r.roll_adjust_out = ra[25:0];
      r.pitch_ref_out = 16'(round_up(pitch_ref, 8));
      r.roll_ref_out = 16'(round_up(roll_ref, 8));
      return r;
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // Sender: bursts of items separated by short or long gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Hold the stalled item.
      end else if (burst_left > 0 && sample_q.size() > 0) begin
         sample_on_bus = sample_q.pop_front();
         req_roll_rate <= sample_on_bus.roll_rate;
         req_pitch_rate <= sample_on_bus.pitch_rate;
         req_yaw_rate <= sample_on_bus.yaw_rate;
         req_accel_x <= sample_on_bus.accel_x;
         req_accel_y <= sample_on_bus.accel_y;
         req_accel_z <= sample_on_bus.accel_z;
         req_valid <= 1'b1;
         req_taken = 1'b0;
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 600)
                                                   : $urandom_range(0, 3);
         end
      end
   end

   // Receiver: alternating run and stall stretches, sometimes long.
   int run_left = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (run_left > 0) begin
         rsp_stall <= 1'b0;
         run_left--;
      end else begin
         rsp_stall <= 1'b0;
         run_left = ($urandom_range(0, 9) == 0) ? 3000 : $urandom_range(0, 40);
         stall_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(0, 6);
      end
   end

   // Acceptance on both channels, result checks and the watchdog.
   int quiet_cycles = 0;
   attitude_type exp_att;
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            attitude_q.push_back(predict_attitude(sample_on_bus));
            req_taken = 1'b1;
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (attitude_q.size() == 0) begin
               $error("unexpected result item");
               error_count++;
            end else begin
               exp_att = attitude_q.pop_front();
               check_field("pitch_out", exp_att.pitch_out, rsp_pitch_out);
               check_field("roll_out", exp_att.roll_out, rsp_roll_out);
               check_field("pitch_adjust_out", exp_att.pitch_adjust_out,
                           rsp_pitch_adjust_out);
               check_field("roll_adjust_out", exp_att.roll_adjust_out,
                           rsp_roll_adjust_out);
               check_field("pitch_ref_out", exp_att.pitch_ref_out, rsp_pitch_ref_out);
               check_field("roll_ref_out", exp_att.roll_ref_out, rsp_roll_ref_out);
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Register write, mirrored into the predictor; the block is idle here.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, longint val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      case (idx)
         CSR_GYRO_STEP_GAIN: gyro_gain = val[20:0];
         CSR_COUPLING_GAIN:  coupling_gain = val[15:0];
         CSR_BLEND_WEIGHT:   blend_weight = val[16:0];
         CSR_PITCH_OFFSET:   pitch_offset = val[12:0];
         CSR_ROLL_OFFSET:    roll_offset = val[12:0];
         CSR_ADJUST_GAIN:    adjust_gain = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_all(longint g, longint c, longint w, longint po, longint ro,
                            longint a);
      write_reg(CSR_GYRO_STEP_GAIN, g);
      write_reg(CSR_COUPLING_GAIN, c);
      write_reg(CSR_BLEND_WEIGHT, w);
      write_reg(CSR_PITCH_OFFSET, po);
      write_reg(CSR_ROLL_OFFSET, ro);
      write_reg(CSR_ADJUST_GAIN, a);
   endtask

   task automatic wait_idle();
      while (sample_q.size() != 0 || req_valid || attitude_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic imu_sample_type make_sample(longint rr, longint pr, longint yr,
                                                  longint ax, longint ay, longint az);
      imu_sample_type s;
      s.roll_rate = rr[17:0];
      s.pitch_rate = pr[17:0];
      s.yaw_rate = yr[17:0];
      s.accel_x = ax[15:0];
      s.accel_y = ay[15:0];
      s.accel_z = az[15:0];
      return s;
   endfunction

   function automatic int signed_range(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // Mostly near-level samples under gravity, plus full-range noise, large rates
   // under gravity and single-axis vectors where the reference must hold.
   function automatic imu_sample_type random_sample();
      imu_sample_type s;
      int kind;
      int az;
      kind = $urandom_range(0, 9);
      az = $urandom_range(15000, 17500);
      if ($urandom_range(0, 1) == 1) az = -az;
      if (kind <= 5)
         s = make_sample(signed_range(3000), signed_range(3000), signed_range(3000),
                         signed_range(8000), signed_range(8000), az);
      else if (kind <= 7)
         s = make_sample($urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
      else if (kind == 8)
         case ($urandom_range(0, 2))
            0: s = make_sample(signed_range(500), signed_range(500), 0,
                               signed_range(32768), 0, 0);
            1: s = make_sample(signed_range(500), signed_range(500), 0,
                               0, signed_range(32768), 0);
            default: s = make_sample(signed_range(500), signed_range(500), 0, 0, 0, 0);
         endcase
      else
         s = make_sample(signed_range(131072), signed_range(131072), signed_range(131072),
                         signed_range(4000), signed_range(4000), az);
      return s;
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items under reset settings.
      sample_q.push_back(make_sample(0, 0, 0, 0, 0, 16384));
      sample_q.push_back(make_sample(131071, 131071, 131071, 32767, 32767, 32767));
      sample_q.push_back(make_sample(-131072, -131072, -131072, -32768, -32768, -32768));
      sample_q.push_back(make_sample(1000, -1000, 131071, 0, 0, 0));
      sample_q.push_back(make_sample(-1000, 1000, -131072, 32767, 0, 0));
      sample_q.push_back(make_sample(0, 0, 0, 0, -32768, 0));
      sample_q.push_back(make_sample(0, 0, 0, -32768, 0, 0));
      sample_q.push_back(make_sample(0, 0, 0, 0, 0, -32768));
      sample_q.push_back(make_sample(256, 256, 0, 5000, -5000, 15000));
      sample_q.push_back(make_sample(0, 0, 0, 16384, 16384, 0));
      sample_q.push_back(make_sample(-256, 512, 2000, -16384, 0, 1));
      sample_q.push_back(make_sample(1, -1, -1, 1, -1, 0));
      wait_idle();

      // Extremes, then zero settings with the spare indexes, then a weight above unity.
      write_all(1048576, 65535, 65536, 2560, -2560, 255);
      for (int i = 0; i < 8; i++)
         sample_q.push_back(make_sample(131071, -131072, 131071, 3000, -3000, 16000));
      sample_q.push_back(make_sample(-131072, 131071, -131072, -3000, 3000, -16000));
      wait_idle();
      write_all(0, 0, 0, -2560, 2560, 0);
      write_reg(CSR_SPARE_LO, 2097151);
      write_reg(CSR_SPARE_HI, 12345);
      for (int i = 0; i < 4; i++) sample_q.push_back(random_sample());
      wait_idle();
      write_all(1048576, 65535, 131071, 0, 0, 255);
      for (int i = 0; i < 4; i++) sample_q.push_back(random_sample());
      wait_idle();

      // Random phases across a spread of settings.
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: write_all(GYRO_GAIN_RESET, COUPLING_GAIN_RESET, BLEND_WEIGHT_RESET,
                         -256, 256, ADJUST_GAIN_RESET);
            1: write_all(1048576, 65535, 65536, 2560, 2560, 255);
            2: write_all(0, 0, 0, -2560, -2560, 1);
            default: write_all($urandom_range(0, 1048576), $urandom_range(0, 65535),
                               $urandom_range(0, 65536), signed_range(2560),
                               signed_range(2560), $urandom_range(0, 255));
         endcase
         for (int i = 0; i < 150; i++) sample_q.push_back(random_sample());
         wait_idle();
      end

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
design/caf_pkg.sv
design/complementary_attitude_filter_core.sv
verif/tb.sv
